// File: design/jbt_pkg.sv
package jbt_pkg;

    // widths fixed by the stream format
    localparam int OFFSET_BITS       = 32;
    localparam int KIND_BITS         = 4;
    localparam int IN_TDATA_BITS     = 8;
    localparam int OUT_TDATA_BITS    = 72;
    localparam int POSITION_BITS_DEF = 32;
    localparam int FIFO_DEPTH        = 4;

    typedef logic [KIND_BITS-1:0] kind_t;

    // token kinds
    localparam kind_t KIND_NULL     = 4'd0;
    localparam kind_t KIND_FALSE    = 4'd1;
    localparam kind_t KIND_TRUE     = 4'd2;
    localparam kind_t KIND_STRING   = 4'd3;
    localparam kind_t KIND_NUMBER   = 4'd4;
    localparam kind_t KIND_LBRACKET = 4'd5;
    localparam kind_t KIND_RBRACKET = 4'd6;
    localparam kind_t KIND_LBRACE   = 4'd7;
    localparam kind_t KIND_RBRACE   = 4'd8;
    localparam kind_t KIND_COLON    = 4'd9;
    localparam kind_t KIND_COMMA    = 4'd10;
    localparam kind_t KIND_ERROR    = 4'd11;

    // keyword selectors
    localparam logic [1:0] KW_NULL  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_TRUE  = 2'd2;

    // byte codes
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_POINT    = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_UPPER_E  = 8'h45;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_S        = 8'h73;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // one result as it leaves the block
    typedef struct packed {
        kind_t                  token_kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   last_result;
    } result_t;

    // up to two results written into the result queue per beat
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // bytes that follow the first letter of each keyword
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_U;
        case (kw)
            KW_FALSE:
            begin
                case (idx)
                    3'd0:    ch = CH_A;
                    3'd1:    ch = CH_L;
                    3'd2:    ch = CH_S;
                    default: ch = CH_E;
                endcase
            end
            KW_TRUE:
            begin
                case (idx)
                    3'd0:    ch = CH_R;
                    3'd1:    ch = CH_U;
                    default: ch = CH_E;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0:    ch = CH_U;
                    default: ch = CH_L;
                endcase
            end
        endcase
        return ch;
    endfunction

    // tail length of each keyword
    function automatic logic [2:0] kw_len(input logic [1:0] kw);
        logic [2:0] len;
        case (kw)
            KW_FALSE: len = 3'd4;
            default:  len = 3'd3;
        endcase
        return len;
    endfunction

endpackage

// File: design/jbt_lexer.sv
module jbt_lexer #(
    parameter int POSITION_BITS = jbt_pkg::POSITION_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_eoi,
    input  logic                   room,
    output jbt_pkg::push_t         push
);
    import jbt_pkg::*;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_KEYWORD = 5'b00010,
        MODE_STRING  = 5'b00100,
        MODE_ESCAPE  = 5'b01000,
        MODE_NUMBER  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic       emit;
        kind_t      kind;
        mode_t      mode;
        logic [1:0] kw;
        logic       open;
    } idle_t;

    // byte lexed with no token open
    function automatic idle_t lex_idle(input logic [7:0] c);
        idle_t r;
        r.emit = 1'b0;
        r.kind = KIND_ERROR;
        r.mode = MODE_IDLE;
        r.kw   = KW_NULL;
        r.open = 1'b0;
        case (c)
            CH_TAB, CH_LF, CH_CR, CH_SPACE: ;
            CH_N:
            begin
                r.mode = MODE_KEYWORD; r.kw = KW_NULL; r.open = 1'b1;
            end
            CH_F:
            begin
                r.mode = MODE_KEYWORD; r.kw = KW_FALSE; r.open = 1'b1;
            end
            CH_T:
            begin
                r.mode = MODE_KEYWORD; r.kw = KW_TRUE; r.open = 1'b1;
            end
            CH_QUOTE:
            begin
                r.mode = MODE_STRING; r.open = 1'b1;
            end
            CH_LBRACKET: begin r.emit = 1'b1; r.kind = KIND_LBRACKET; end
            CH_RBRACKET: begin r.emit = 1'b1; r.kind = KIND_RBRACKET; end
            CH_LBRACE:   begin r.emit = 1'b1; r.kind = KIND_LBRACE;   end
            CH_RBRACE:   begin r.emit = 1'b1; r.kind = KIND_RBRACE;   end
            CH_COLON:    begin r.emit = 1'b1; r.kind = KIND_COLON;    end
            CH_COMMA:    begin r.emit = 1'b1; r.kind = KIND_COMMA;    end
            default:
            begin
                if (c inside {CH_MINUS, [CH_ZERO:CH_NINE]})
                begin
                    r.mode = MODE_NUMBER; r.open = 1'b1;
                end
                else
                begin
                    r.emit = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // input register
    logic                     item_valid_reg, item_valid_next;
    logic [7:0]               item_byte_reg;
    logic                     item_eoi_reg;
    logic                     advance;

    // lexer state
    mode_t                    mode_reg, mode_next;
    logic [1:0]               kw_kind_reg, kw_kind_next;
    logic [2:0]               kw_index_reg, kw_index_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;

    logic [POSITION_BITS-1:0] prev_pos;
    logic [OFFSET_BITS-1:0]   pos_off, prev_off, start_off;
    idle_t                    idle_res;
    logic                     use_idle;
    logic [1:0]               kw_k;
    logic [2:0]               kw_i, kw_i1;
    logic                     a_valid;
    kind_t                    a_kind;
    logic [OFFSET_BITS-1:0]   a_end;
    result_t                  res_a, res_b;

    assign advance         = item_valid_reg & room;
    assign in_ready        = ~item_valid_reg | room;
    assign item_valid_next = (in_valid & in_ready) | (item_valid_reg & ~room);
    assign prev_pos        = pos_reg - POSITION_BITS'(1);

    // offsets carry the low 32 bits of a position
    generate
        if (POSITION_BITS >= OFFSET_BITS)
        begin : g_wide
            assign pos_off   = pos_reg[OFFSET_BITS-1:0];
            assign prev_off  = prev_pos[OFFSET_BITS-1:0];
            assign start_off = start_reg[OFFSET_BITS-1:0];
        end
        else
        begin : g_narrow
            assign pos_off   = OFFSET_BITS'(pos_reg);
            assign prev_off  = OFFSET_BITS'(prev_pos);
            assign start_off = OFFSET_BITS'(start_reg);
        end
    endgenerate

    // input beat capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_byte_reg <= in_byte;
            item_eoi_reg  <= in_eoi;
        end
    end

    // one lexing step on the held byte
    always_comb
    begin
        mode_next     = mode_reg;
        kw_kind_next  = kw_kind_reg;
        kw_index_next = kw_index_reg;
        pos_next      = pos_reg + POSITION_BITS'(1);
        start_next    = start_reg;
        a_valid       = 1'b0;
        a_kind        = KIND_ERROR;
        a_end         = pos_off;
        use_idle      = 1'b0;
        idle_res      = lex_idle(item_byte_reg);
        kw_k          = (kw_kind_reg == KW_FALSE || kw_kind_reg == KW_TRUE) ?
                        kw_kind_reg : KW_NULL;
        kw_i          = (kw_index_reg < kw_len(kw_k)) ? kw_index_reg : 3'd0;
        kw_i1         = kw_i + 3'd1;

        if (item_eoi_reg)
        begin
            // flush whatever token is open
            a_end         = prev_off;
            a_valid       = (mode_reg != MODE_IDLE);
            a_kind        = (mode_reg == MODE_NUMBER) ? KIND_NUMBER : KIND_ERROR;
            mode_next     = MODE_IDLE;
            kw_index_next = 3'd0;
            pos_next      = '0;
            start_next    = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_KEYWORD:
                begin
                    if (item_byte_reg == kw_char(kw_k, kw_i))
                    begin
                        kw_index_next = kw_i1;
                        if (kw_i1 >= kw_len(kw_k))
                        begin
                            a_valid       = 1'b1;
                            a_kind        = KIND_BITS'(kw_k);
                            mode_next     = MODE_IDLE;
                            kw_index_next = 3'd0;
                        end
                    end
                    else
                    begin
                        a_valid       = 1'b1;
                        mode_next     = MODE_IDLE;
                        kw_index_next = 3'd0;
                    end
                end
                MODE_STRING:
                begin
                    if (item_byte_reg == CH_QUOTE)
                    begin
                        a_valid   = 1'b1;
                        a_kind    = KIND_STRING;
                        mode_next = MODE_IDLE;
                    end
                    else if (item_byte_reg == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_STRING;
                end
                MODE_NUMBER:
                begin
                    if (!(item_byte_reg inside {[CH_ZERO:CH_NINE], CH_PLUS, CH_MINUS,
                                                CH_POINT, CH_E, CH_UPPER_E}))
                    begin
                        a_valid  = 1'b1;
                        a_kind   = KIND_NUMBER;
                        a_end    = prev_off;
                        use_idle = 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    use_idle = 1'b1;
                end
                default:
                begin
                    use_idle = 1'b1;
                end
            endcase

            // the byte starts fresh in idle
            if (use_idle)
            begin
                mode_next = idle_res.mode;
                if (idle_res.open)
                begin
                    start_next = pos_reg;
                    if (idle_res.mode == MODE_KEYWORD)
                    begin
                        kw_kind_next  = idle_res.kw;
                        kw_index_next = 3'd0;
                    end
                end
            end
        end
    end

    // results in order, last flag on the final one
    always_comb
    begin
        res_a.token_kind   = a_kind;
        res_a.start_offset = start_off;
        res_a.end_offset   = a_end;
        res_a.last_result  = 1'b1;
        res_b.token_kind   = idle_res.kind;
        res_b.start_offset = pos_off;
        res_b.end_offset   = pos_off;
        res_b.last_result  = 1'b1;
        push.first         = res_a;
        push.second        = res_b;
        push.count         = 2'd0;
        if (a_valid && use_idle && idle_res.emit)
        begin
            push.first.last_result = 1'b0;
            push.count             = 2'd2;
        end
        else if (a_valid)
        begin
            push.count = 2'd1;
        end
        else if (use_idle && idle_res.emit)
        begin
            push.first = res_b;
            push.count = 2'd1;
        end
        if (!advance)
        begin
            push.count = 2'd0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            kw_kind_reg  <= KW_NULL;
            kw_index_reg <= 3'd0;
            pos_reg      <= '0;
            start_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            kw_kind_reg  <= kw_kind_next;
            kw_index_reg <= kw_index_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
        end
    end

    // two results come only from a byte that closes a number
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> mode_reg == MODE_NUMBER)
        else $error("second result without an open number");

    // end of text restarts the offsets at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_eoi_reg |=> pos_reg == '0 && mode_reg == MODE_IDLE)
        else $error("end of text did not clear the position");

    // keyword match count stays inside the keyword
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_KEYWORD |-> kw_index_reg < kw_len(kw_kind_reg))
        else $error("keyword index out of range");

endmodule

// File: design/jbt_result_fifo.sv
module jbt_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  jbt_pkg::push_t     push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output jbt_pkg::result_t   out_res
);
    import jbt_pkg::*;

    localparam int PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    result_t               mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic                  pop;

    assign room      = (count_reg <= CNT_BITS'(FIFO_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage, one or two writes per beat
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_BITS'(1)] <= push.second;
        end
    end

    // never written past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> count_reg <= CNT_BITS'(FIFO_DEPTH - 2))
        else $error("result queue overflow");

endmodule

// File: design/json_byte_tokenizer_core.sv
// channel | direction | tdata (low bit up)                         | tlast
// s_*     | in        | data_byte[7:0]                             | end_of_input
// m_*     | out       | token_kind, start_offset, end_offset, pad  | last_result
//
// one byte is taken every cycle while the result queue has room; each byte gives zero, one or two tokens
// a byte that closes a number can give two tokens; the queue takes both at once
// an input beat reaches m_* through the input register and then the result queue
// rst_n clears the lexer state and the result queue; offsets restart at zero
// a stall on m_* backs up through a four-entry result queue into s_tready
module json_byte_tokenizer_core #(
    parameter int POSITION_BITS = jbt_pkg::POSITION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [jbt_pkg::IN_TDATA_BITS-1:0]   s_tdata,  // data_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [jbt_pkg::OUT_TDATA_BITS-1:0]  m_tdata,  // token_kind, start_offset, end_offset
    output logic                                m_tlast
);
    import jbt_pkg::*;

    push_t   push;
    logic    room;
    result_t out_res;

    // lexer with its input register
    jbt_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eoi   (s_tlast),
        .room     (room),
        .push     (push)
    );

    // result queue toward the output side
    jbt_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // output beat packing
    assign m_tdata = {(OUT_TDATA_BITS - KIND_BITS - 2*OFFSET_BITS)'(0),
                      out_res.end_offset, out_res.start_offset, out_res.token_kind};
    assign m_tlast = out_res.last_result;

endmodule
